// ===== hw/rtl/wcq_pkg.sv =====
`default_nettype none

package wcq_pkg;

  // fixed field widths
  localparam int unsigned ROOM_W      = 13;
  localparam int unsigned IN_TIME_W   = 32;
  localparam int unsigned OUT_TIME_W  = 32;
  localparam int unsigned PCOUNT_W    = 6;
  localparam int unsigned ECOUNT_W    = 16;

  // parameter defaults
  localparam int unsigned CAPACITY_DEF  = 32;
  localparam int unsigned TIME_BITS_DEF = 32;

  typedef enum logic {
    ACT_REGISTER = 1'b0,
    ACT_TICK     = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED  = 2'd0,
    KIND_REJECTED  = 2'd1,
    KIND_WAKE      = 2'd2,
    KIND_IDLE_TICK = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_TOP_RD,
    S_TOP_CMP,
    S_LAST,
    S_DN_RD,
    S_DN_L,
    S_DN_R,
    S_DN_CMP
  } state_e;

  typedef struct packed {
    action_e               action;
    logic [ROOM_W-1:0]     room;
    logic [IN_TIME_W-1:0]  call_time;
    logic [IN_TIME_W-1:0]  now;
  } cmd_t;

  typedef struct packed {
    kind_e                 kind;
    logic [ROOM_W-1:0]     woken_room;
    logic [OUT_TIME_W-1:0] woken_time;
    logic [PCOUNT_W-1:0]   pending_count;
    logic [ECOUNT_W-1:0]   expired_count;
    logic                  last;
  } res_t;

  // wake-up beat held back until it is known whether another one follows
  typedef struct packed {
    logic                  valid;
    logic [ROOM_W-1:0]     room;
    logic [OUT_TIME_W-1:0] due;
    logic [PCOUNT_W-1:0]   pcount;
    logic [ECOUNT_W-1:0]   ecount;
  } pend_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wcq_ram.sv =====
`default_nettype none

module wcq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wcq_cmp.sv =====
`default_nettype none

module wcq_cmp #(
  parameter int unsigned Width = 32
) (
  input  wire logic [Width-1:0] a_i,
  input  wire logic [Width-1:0] b_i,
  output logic                  lt_o
);

  // shared unsigned magnitude compare
  assign lt_o = (a_i < b_i);

endmodule

`default_nettype wire

// ===== hw/rtl/wakeup_call_timer_queue.sv =====
`default_nettype none

// Wake-up call timer queue: pending (room, due time) calls sit in a binary
// min-heap on due time, held in one single-port-read RAM and ordered by one
// shared comparator under a small sequencer. A register beat fetches and
// compares one parent per heap level climbed. A tick beat looks at the
// root, and for each call it delivers it fetches the last entry, sifts it
// down one heap level at a time (reading the left child, then the right
// child where there is one, then comparing), lets it settle and looks at
// the new root; a tick with nothing due answers once it has looked at the
// root, or straight away on an empty heap. The RAM's one read port and the
// one comparator set this order of steps. busy_o is high while a
// beat is being worked on and start_i is only taken while it is low. Results
// come out on res_o for exactly one cycle each, marked by res_valid_o; the
// receiver cannot stall them, so it must take every beat as it appears. A
// tick emits one beat per due call with last set on the final one, or a
// single nothing-due beat. The heap RAM needs no clearing after reset.
module wakeup_call_timer_queue #(
  parameter int unsigned CAPACITY  = wcq_pkg::CAPACITY_DEF,
  parameter int unsigned TIME_BITS = wcq_pkg::TIME_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire wcq_pkg::cmd_t cmd_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output wcq_pkg::res_t      res_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned EntW  = TIME_BITS + wcq_pkg::ROOM_W;

  wcq_pkg::state_e state_q, state_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [wcq_pkg::ECOUNT_W-1:0] exp_q, exp_d, exp_inc;
  logic [TIME_BITS-1:0]         now_q, now_d;
  logic [EntW-1:0]              mov_q, mov_d;
  logic [EntW-1:0]              best_q, best_d;
  logic [CntW-1:0]              pos_q, pos_d;
  logic [CntW:0]                child_q, child_d, child_w;
  wcq_pkg::pend_t               pend_q, pend_d;
  logic                         res_valid_q, res_valid_d;
  wcq_pkg::res_t                res_q, res_d;

  logic             accept;
  logic             full_w;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [EntW-1:0]  wr_data, rd_data;
  logic [TIME_BITS-1:0] cmp_a, cmp_b;
  logic             lt;

  function automatic wcq_pkg::res_t make_res(
    wcq_pkg::kind_e                  kind,
    logic [wcq_pkg::ROOM_W-1:0]      room,
    logic [wcq_pkg::OUT_TIME_W-1:0]  due,
    logic [wcq_pkg::PCOUNT_W-1:0]    pcount,
    logic [wcq_pkg::ECOUNT_W-1:0]    ecount,
    logic                            last
  );
    wcq_pkg::res_t r;
    r.kind          = kind;
    r.woken_room    = room;
    r.woken_time    = due;
    r.pending_count = pcount;
    r.expired_count = ecount;
    r.last          = last;
    return r;
  endfunction

  assign accept  = start_i && (state_q == wcq_pkg::S_IDLE);
  assign full_w  = (cnt_q == CntW'(CAPACITY));
  assign child_w = {pos_q, 1'b0};
  assign exp_inc = (exp_q == '1) ? exp_q : exp_q + 1'b1;

  // heap storage, entry = {room, due}
  wcq_ram #(
    .Width(EntW),
    .Depth(CAPACITY)
  ) u_heap (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // comparator operand select
  always_comb begin
    cmp_a = mov_q[TIME_BITS-1:0];
    cmp_b = best_q[TIME_BITS-1:0];
    unique case (state_q)
      wcq_pkg::S_UP_CMP: begin
        cmp_a = mov_q[TIME_BITS-1:0];
        cmp_b = rd_data[TIME_BITS-1:0];
      end
      wcq_pkg::S_TOP_CMP: begin
        cmp_a = now_q;
        cmp_b = rd_data[TIME_BITS-1:0];
      end
      wcq_pkg::S_DN_R: begin
        cmp_a = rd_data[TIME_BITS-1:0];
        cmp_b = best_q[TIME_BITS-1:0];
      end
      wcq_pkg::S_DN_CMP: begin
        cmp_a = best_q[TIME_BITS-1:0];
        cmp_b = mov_q[TIME_BITS-1:0];
      end
      default: begin
        cmp_a = mov_q[TIME_BITS-1:0];
        cmp_b = best_q[TIME_BITS-1:0];
      end
    endcase
  end

  wcq_cmp #(
    .Width(TIME_BITS)
  ) u_cmp (
    .a_i (cmp_a),
    .b_i (cmp_b),
    .lt_o(lt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wcq_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_i.action == wcq_pkg::ACT_TICK) begin
            state_d = wcq_pkg::S_TOP_RD;
          end else if (!full_w) begin
            state_d = wcq_pkg::S_UP_RD;
          end
        end
      end
      wcq_pkg::S_UP_RD: begin
        if (pos_q == CntW'(1)) begin
          state_d = wcq_pkg::S_IDLE;
        end else begin
          state_d = wcq_pkg::S_UP_CMP;
        end
      end
      wcq_pkg::S_UP_CMP: begin
        state_d = lt ? wcq_pkg::S_UP_RD : wcq_pkg::S_IDLE;
      end
      wcq_pkg::S_TOP_RD: begin
        state_d = (cnt_q == '0) ? wcq_pkg::S_IDLE : wcq_pkg::S_TOP_CMP;
      end
      wcq_pkg::S_TOP_CMP: begin
        state_d = lt ? wcq_pkg::S_IDLE : wcq_pkg::S_LAST;
      end
      wcq_pkg::S_LAST: begin
        state_d = (cnt_q == '0) ? wcq_pkg::S_TOP_RD : wcq_pkg::S_DN_RD;
      end
      wcq_pkg::S_DN_RD: begin
        if (child_w > {1'b0, cnt_q}) begin
          state_d = wcq_pkg::S_TOP_RD;
        end else begin
          state_d = wcq_pkg::S_DN_L;
        end
      end
      wcq_pkg::S_DN_L: begin
        if (child_q != {1'b0, cnt_q}) begin
          state_d = wcq_pkg::S_DN_R;
        end else begin
          state_d = wcq_pkg::S_DN_CMP;
        end
      end
      wcq_pkg::S_DN_R: begin
        state_d = wcq_pkg::S_DN_CMP;
      end
      wcq_pkg::S_DN_CMP: begin
        state_d = lt ? wcq_pkg::S_DN_RD : wcq_pkg::S_TOP_RD;
      end
      default: begin
        state_d = wcq_pkg::S_IDLE;
      end
    endcase
  end

  // datapath, memory control and result beats
  always_comb begin
    cnt_d       = cnt_q;
    exp_d       = exp_q;
    now_d       = now_q;
    mov_d       = mov_q;
    best_d      = best_q;
    pos_d       = pos_q;
    child_d     = child_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_addr     = AddrW'(pos_q - 1'b1);
    wr_data     = mov_q;
    rd_en       = 1'b0;
    rd_addr     = '0;

    unique case (state_q)
      wcq_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_i.action == wcq_pkg::ACT_TICK) begin
            now_d        = TIME_BITS'(cmd_i.now);
            pend_d.valid = 1'b0;
          end else if (full_w) begin
            res_valid_d = 1'b1;
            res_d = make_res(wcq_pkg::KIND_REJECTED, '0, '0,
                             wcq_pkg::PCOUNT_W'(cnt_q), exp_q, 1'b1);
          end else begin
            cnt_d = cnt_q + 1'b1;
            pos_d = cnt_q + 1'b1;
            mov_d = {cmd_i.room, TIME_BITS'(cmd_i.call_time)};
          end
        end
      end

      // sift-up: fetch parent or settle at the root
      wcq_pkg::S_UP_RD: begin
        if (pos_q == CntW'(1)) begin
          wr_en       = 1'b1;
          res_valid_d = 1'b1;
          res_d = make_res(wcq_pkg::KIND_ACCEPTED, '0, '0,
                           wcq_pkg::PCOUNT_W'(cnt_q), exp_q, 1'b1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = AddrW'((pos_q >> 1) - 1'b1);
        end
      end

      // parent later than the new call moves down
      wcq_pkg::S_UP_CMP: begin
        wr_en = 1'b1;
        if (lt) begin
          wr_data = rd_data;
          pos_d   = pos_q >> 1;
        end else begin
          res_valid_d = 1'b1;
          res_d = make_res(wcq_pkg::KIND_ACCEPTED, '0, '0,
                           wcq_pkg::PCOUNT_W'(cnt_q), exp_q, 1'b1);
        end
      end

      // look at the root, or close the tick on an empty heap
      wcq_pkg::S_TOP_RD: begin
        if (cnt_q == '0) begin
          res_valid_d = 1'b1;
          if (pend_q.valid) begin
            res_d = make_res(wcq_pkg::KIND_WAKE, pend_q.room, pend_q.due,
                             pend_q.pcount, pend_q.ecount, 1'b1);
          end else begin
            res_d = make_res(wcq_pkg::KIND_IDLE_TICK, '0, '0,
                             wcq_pkg::PCOUNT_W'(cnt_q), exp_q, 1'b1);
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end

      // root due: pop it and fetch the last entry
      wcq_pkg::S_TOP_CMP: begin
        res_valid_d = pend_q.valid || lt;
        if (pend_q.valid) begin
          res_d = make_res(wcq_pkg::KIND_WAKE, pend_q.room, pend_q.due,
                           pend_q.pcount, pend_q.ecount, lt);
        end else begin
          res_d = make_res(wcq_pkg::KIND_IDLE_TICK, '0, '0,
                           wcq_pkg::PCOUNT_W'(cnt_q), exp_q, 1'b1);
        end
        if (!lt) begin
          exp_d         = exp_inc;
          cnt_d         = cnt_q - 1'b1;
          pend_d.valid  = 1'b1;
          pend_d.room   = rd_data[TIME_BITS +: wcq_pkg::ROOM_W];
          pend_d.due    = wcq_pkg::OUT_TIME_W'(rd_data[TIME_BITS-1:0]);
          pend_d.pcount = wcq_pkg::PCOUNT_W'(cnt_q - 1'b1);
          pend_d.ecount = exp_inc;
          rd_en         = 1'b1;
          rd_addr       = AddrW'(cnt_q - 1'b1);
        end
      end

      // last entry becomes the one sifting down from the root
      wcq_pkg::S_LAST: begin
        mov_d = rd_data;
        pos_d = CntW'(1);
      end

      // sift-down: fetch left child or settle
      wcq_pkg::S_DN_RD: begin
        if (child_w > {1'b0, cnt_q}) begin
          wr_en = 1'b1;
        end else begin
          child_d = child_w;
          rd_en   = 1'b1;
          rd_addr = AddrW'(child_w - 1'b1);
        end
      end

      wcq_pkg::S_DN_L: begin
        best_d = rd_data;
        if (child_q != {1'b0, cnt_q}) begin
          rd_en   = 1'b1;
          rd_addr = AddrW'(child_q);
        end
      end

      // right child wins only when strictly earlier
      wcq_pkg::S_DN_R: begin
        if (lt) begin
          best_d  = rd_data;
          child_d = child_q + 1'b1;
        end
      end

      wcq_pkg::S_DN_CMP: begin
        wr_en = 1'b1;
        if (lt) begin
          wr_data = best_q;
          pos_d   = CntW'(child_q);
        end
      end

      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wcq_pkg::S_IDLE;
      cnt_q       <= '0;
      exp_q       <= '0;
      pend_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      exp_q       <= exp_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    mov_q   <= mov_d;
    best_q  <= best_d;
    pos_q   <= pos_d;
    child_q <= child_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != wcq_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // the final beat of an item coincides with the sequencer going idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (busy_o != res_o.last))
    else $error("last flag out of step with sequencer");

  // only wake-up beats may be followed by more beats of the same item
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind != wcq_pkg::KIND_WAKE)) |-> res_o.last)
    else $error("non-wake beat without last");

  // the heap never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // an accepted beat either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || res_valid_o))
    else $error("accepted beat dropped");
`endif

endmodule

`default_nettype wire
